[hw/rtl/bce_pkg.sv]
// Shared types and constants for the battery charge estimator.
package bce_pkg;

    // Reference temperature for voltage compensation, tenths of a degree C
    localparam int TEMP_REF_DECI_C = 250;

    localparam logic [16:0] Q16_ONE     = 17'd65536;
    localparam logic [23:0] RUNTIME_MAX = 24'hFFFFFF;
    localparam int          UNIT_W      = 64;
    localparam logic [6:0]  DIV_STEPS   = 7'd64;

    // Configuration register indexes
    localparam logic [2:0] CFG_EMPTY_V   = 3'd0;
    localparam logic [2:0] CFG_FULL_V    = 3'd1;
    localparam logic [2:0] CFG_MARGIN_V  = 3'd2;
    localparam logic [2:0] CFG_SAFETY    = 3'd3;
    localparam logic [2:0] CFG_ALPHA     = 3'd4;
    localparam logic [2:0] CFG_RUN_MIN   = 3'd5;
    localparam logic [2:0] CFG_TEMP_COEF = 3'd6;
    localparam logic [2:0] CFG_INIT_V    = 3'd7;

    // Warning codes: WARN_OK, then the warnings from highest priority down
    localparam logic [2:0] WARN_OK          = 3'd0;
    localparam logic [2:0] WARN_NO_VSTATE   = 3'd1;
    localparam logic [2:0] WARN_NO_CAPACITY = 3'd2;
    localparam logic [2:0] WARN_CRIT_TEMP   = 3'd3;
    localparam logic [2:0] WARN_HIGH_TEMP   = 3'd4;
    localparam logic [2:0] WARN_CRIT_BATT   = 3'd5;
    localparam logic [2:0] WARN_LOW_BATT    = 3'd6;
    localparam logic [2:0] WARN_LOW_RUNTIME = 3'd7;

    typedef struct packed {
        logic [23:0]        dt_ms;
        logic               current_seen;
        logic signed [15:0] avg_current_ma;
        logic signed [11:0] temp_deci_c;
        logic [15:0]        capacity_mah;
        logic               voltage_state_seen;
        logic               voltage_present;
        logic               standstill;
        logic [15:0]        voltage_mv;
    } t_in_item;

    typedef struct packed {
        logic [15:0] abs_current_ma;
        logic [38:0] consumed_charge;
        logic [37:0] remaining_charge;
        logic [9:0]  remaining_permille;
        logic        runtime_valid;
        logic [23:0] runtime_deci_min;
        logic        voltage_estimate_valid;
        logic [37:0] voltage_charge_estimate;
        logic [2:0]  warning_code;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV
    } t_op;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PREP,
        ST_FULL,
        ST_USED,
        ST_VMUL,
        ST_VDIV,
        ST_VSAFE,
        ST_INIT,
        ST_ISAFE,
        ST_CC,
        ST_BL1,
        ST_BL2,
        ST_PERM,
        ST_PMUL,
        ST_PDIV,
        ST_RUN,
        ST_RMUL,
        ST_RDIV,
        ST_LMUL,
        ST_DONE
    } t_state;

endpackage

[hw/rtl/battery_charge_estimator_unit.sv]
// Battery fuel gauge: coulomb counting with idle-voltage correction.
// Each result waits on the shared bit-serial multiply/divide unit, one bit per cycle.
// One tick at a time; the next is taken in the cycle after the result is queued.
// A tick without current data is absorbed with no result.
// Reset (synchronous, active low) restores register defaults and clears charge.
module battery_charge_estimator_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  bce_pkg::t_in_item    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output bce_pkg::t_out_item   o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [16:0]          i_cfg_data
);
    import bce_pkg::*;

    // Configuration registers
    logic [15:0]        r_empty_v, r_full_v, r_margin_v;
    logic [16:0]        r_safety, r_alpha;
    logic [14:0]        r_run_min;
    logic signed [10:0] r_temp_coef;
    logic               r_init_v;

    // Sequencer and tick state
    t_state             r_state, n_state;
    t_in_item           r_in, n_in;
    logic [15:0]        r_cur, n_cur;
    logic [19:0]        r_vn, n_vn, r_vd, n_vd;
    logic               r_vmid, n_vmid, r_vfull, n_vfull, r_vest, n_vest;
    logic [37:0]        r_full, n_full, r_est, n_est, r_store, n_store;
    logic [37:0]        r_rem, n_rem;
    logic [38:0]        r_used, n_used;
    logic               r_init, n_init;
    logic [9:0]         r_permille, n_permille;
    logic               r_run_ok, n_run_ok, r_low_run, n_low_run;
    logic [23:0]        r_runtime, n_runtime;
    t_out_item          r_out, n_out;
    logic               r_out_valid, n_out_valid;

    // Shared multiply/divide unit
    logic [63:0]        r_acc, n_acc, r_mcand, n_mcand, r_mplier, n_mplier;
    logic [6:0]         r_cnt, n_cnt;
    logic               r_run, n_run;
    t_op                r_op, n_op;

    // Launch request from the sequencer
    logic               l_go, l_keep;
    t_op                l_op;
    logic [63:0]        l_a, l_b;
    logic [6:0]         l_n;

    // Helper values
    logic [16:0]        w_safety, w_alpha;
    logic [19:0]        w_vx10, w_mx10, w_ex10, w_fx10;
    logic signed [12:0] w_tdiff;
    logic signed [23:0] w_tc;
    logic signed [25:0] w_n, w_d;
    logic [63:0]        w_rem_sh;
    logic [38:0]        w_cc_raw;
    logic [37:0]        w_cc, w_blend;
    logic [41:0]        w_rem10;
    logic [40:0]        w_rem5;
    logic [2:0]         w_warn;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    assign w_safety = (r_safety > Q16_ONE) ? Q16_ONE : r_safety;
    assign w_alpha  = (r_alpha > Q16_ONE) ? Q16_ONE : r_alpha;

    // Compensated voltage fraction, tenths of a millivolt
    assign w_vx10  = {1'b0, r_in.voltage_mv, 3'b0} + {3'b0, r_in.voltage_mv, 1'b0};
    assign w_mx10  = {1'b0, r_margin_v, 3'b0} + {3'b0, r_margin_v, 1'b0};
    assign w_ex10  = {1'b0, r_empty_v, 3'b0} + {3'b0, r_empty_v, 1'b0};
    assign w_fx10  = {1'b0, r_full_v, 3'b0} + {3'b0, r_full_v, 1'b0};
    assign w_tdiff = 13'(TEMP_REF_DECI_C) - {r_in.temp_deci_c[11], r_in.temp_deci_c};
    assign w_tc    = 24'(r_temp_coef) * 24'(w_tdiff);
    assign w_n     = $signed({6'b0, w_vx10}) + 26'(w_tc) - $signed({6'b0, w_mx10})
                   - $signed({6'b0, w_ex10});
    assign w_d     = $signed({6'b0, w_fx10}) - $signed({6'b0, w_ex10});

    // Coulomb count: subtract, floor at zero, cap at full
    assign w_cc_raw = ({1'b0, r_store} > r_used) ? ({1'b0, r_store} - r_used) : 39'd0;
    assign w_cc     = (w_cc_raw > {1'b0, r_full}) ? r_full : w_cc_raw[37:0];
    assign w_blend  = (r_acc[53:16] > r_full) ? r_full : r_acc[53:16];

    assign w_rem_sh = {r_acc[62:0], r_mplier[63]};
    assign w_rem10  = {1'b0, r_rem, 3'b0} + {3'b0, r_rem, 1'b0};
    assign w_rem5   = {1'b0, r_rem, 2'b0} + {3'b0, r_rem};

    // Prioritized warning
    always_comb begin
        if (!r_in.voltage_state_seen) begin
            w_warn = WARN_NO_VSTATE;
        end else if (r_in.capacity_mah == 16'd0) begin
            w_warn = WARN_NO_CAPACITY;
        end else if (r_in.temp_deci_c >= 12'sd600) begin
            w_warn = WARN_CRIT_TEMP;
        end else if (r_in.temp_deci_c >= 12'sd500) begin
            w_warn = WARN_HIGH_TEMP;
        end else if (w_rem10 <= {4'b0, r_full}) begin
            w_warn = WARN_CRIT_BATT;
        end else if (w_rem5 <= {3'b0, r_full}) begin
            w_warn = WARN_LOW_BATT;
        end else if (r_low_run) begin
            w_warn = WARN_LOW_RUNTIME;
        end else begin
            w_warn = WARN_OK;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty_v   <= 16'd17200;
            r_full_v    <= 16'd20500;
            r_margin_v  <= 16'd200;
            r_safety    <= 17'd65536;
            r_alpha     <= 17'd52429;
            r_run_min   <= 15'd500;
            r_temp_coef <= 11'sd0;
            r_init_v    <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_EMPTY_V:   r_empty_v   <= i_cfg_data[15:0];
                CFG_FULL_V:    r_full_v    <= i_cfg_data[15:0];
                CFG_MARGIN_V:  r_margin_v  <= i_cfg_data[15:0];
                CFG_SAFETY:    r_safety    <= i_cfg_data;
                CFG_ALPHA:     r_alpha     <= i_cfg_data;
                CFG_RUN_MIN:   r_run_min   <= i_cfg_data[14:0];
                CFG_TEMP_COEF: r_temp_coef <= $signed(i_cfg_data[10:0]);
                CFG_INIT_V:    r_init_v    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_run       <= 1'b0;
            r_out_valid <= 1'b0;
            r_init      <= 1'b0;
            r_store     <= 38'd0;
        end else begin
            r_state     <= n_state;
            r_run       <= n_run;
            r_out_valid <= n_out_valid;
            r_init      <= n_init;
            r_store     <= n_store;
        end
    end

    // Payload and datapath registers
    always_ff @(posedge i_clk) begin
        r_in       <= n_in;
        r_cur      <= n_cur;
        r_vn       <= n_vn;
        r_vd       <= n_vd;
        r_vmid     <= n_vmid;
        r_vfull    <= n_vfull;
        r_vest     <= n_vest;
        r_full     <= n_full;
        r_used     <= n_used;
        r_est      <= n_est;
        r_rem      <= n_rem;
        r_permille <= n_permille;
        r_run_ok   <= n_run_ok;
        r_low_run  <= n_low_run;
        r_runtime  <= n_runtime;
        r_out      <= n_out;
        r_acc      <= n_acc;
        r_mcand    <= n_mcand;
        r_mplier   <= n_mplier;
        r_cnt      <= n_cnt;
        r_op       <= n_op;
    end

    // Sequencer, at most one operation of the shared unit per state
    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_cur       = r_cur;
        n_vn        = r_vn;
        n_vd        = r_vd;
        n_vmid      = r_vmid;
        n_vfull     = r_vfull;
        n_vest      = r_vest;
        n_full      = r_full;
        n_used      = r_used;
        n_est       = r_est;
        n_store     = r_store;
        n_init      = r_init;
        n_rem       = r_rem;
        n_permille  = r_permille;
        n_run_ok    = r_run_ok;
        n_low_run   = r_low_run;
        n_runtime   = r_runtime;
        n_out       = r_out;
        n_out_valid = r_out_valid & ~i_out_ready;
        n_acc       = r_acc;
        n_mcand     = r_mcand;
        n_mplier    = r_mplier;
        n_cnt       = r_cnt;
        n_run       = r_run;
        n_op        = r_op;
        l_go        = 1'b0;
        l_keep      = 1'b0;
        l_op        = OP_MUL;
        l_a         = 64'd0;
        l_b         = 64'd0;
        l_n         = 7'd0;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_in_data.current_seen) begin
                    n_in    = i_in_data;
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_cur   = r_in.avg_current_ma[15] ? 16'(-r_in.avg_current_ma)
                                                  : r_in.avg_current_ma;
                n_vn    = w_n[19:0];
                n_vd    = w_d[19:0];
                n_vmid  = (w_d > 26'sd0) && (w_n > 26'sd0) && (w_n < w_d);
                n_vfull = (w_d > 26'sd0) && (w_n >= w_d);
                n_vest  = r_in.voltage_present & r_in.standstill;
                l_go = 1'b1; l_a = 64'd3600000; l_b = 64'(r_in.capacity_mah); l_n = 7'd16;
                n_state = ST_FULL;
            end
            ST_FULL: begin
                if (!r_run) begin
                    n_full = r_acc[37:0];
                    l_go = 1'b1; l_a = 64'(r_in.dt_ms); l_b = 64'(r_cur); l_n = 7'd16;
                    n_state = ST_USED;
                end
            end
            ST_USED: begin
                if (!r_run) begin
                    n_used = r_acc[38:0];
                    if (!r_vest) begin
                        n_est   = 38'd0;
                        n_state = ST_INIT;
                    end else if (r_vmid) begin
                        l_go = 1'b1; l_a = 64'(r_full); l_b = 64'(r_vn); l_n = 7'd20;
                        n_state = ST_VMUL;
                    end else begin
                        l_go = 1'b1; l_a = r_vfull ? 64'(r_full) : 64'd0;
                        l_b = 64'(w_safety); l_n = 7'd17;
                        n_state = ST_VSAFE;
                    end
                end
            end
            ST_VMUL: begin
                if (!r_run) begin
                    l_go = 1'b1; l_op = OP_DIV; l_a = 64'(r_vd); l_b = r_acc;
                    l_n = DIV_STEPS;
                    n_state = ST_VDIV;
                end
            end
            ST_VDIV: begin
                if (!r_run) begin
                    l_go = 1'b1; l_a = 64'(r_mplier[37:0]); l_b = 64'(w_safety); l_n = 7'd17;
                    n_state = ST_VSAFE;
                end
            end
            ST_VSAFE: begin
                if (!r_run) begin
                    n_est   = r_acc[53:16];
                    n_state = ST_INIT;
                end
            end
            ST_INIT: begin
                if (r_init) begin
                    n_state = ST_CC;
                end else if (r_init_v && r_vest) begin
                    n_store = r_est;
                    n_init  = 1'b1;
                    n_state = ST_CC;
                end else begin
                    l_go = 1'b1; l_a = 64'(r_full); l_b = 64'(w_safety); l_n = 7'd17;
                    n_state = ST_ISAFE;
                end
            end
            ST_ISAFE: begin
                if (!r_run) begin
                    n_store = r_acc[53:16];
                    n_init  = 1'b1;
                    n_state = ST_CC;
                end
            end
            ST_CC: begin
                if (r_vest) begin
                    l_go = 1'b1; l_a = 64'(w_cc); l_b = 64'(w_alpha); l_n = 7'd17;
                    n_state = ST_BL1;
                end else begin
                    n_rem   = w_cc;
                    n_state = ST_PERM;
                end
            end
            ST_BL1: begin
                if (!r_run) begin
                    // accumulate the voltage share on top of the coulomb share
                    l_go = 1'b1; l_keep = 1'b1; l_a = 64'(r_est);
                    l_b = 64'(Q16_ONE - w_alpha); l_n = 7'd17;
                    n_state = ST_BL2;
                end
            end
            ST_BL2: begin
                if (!r_run) begin
                    n_rem   = w_blend;
                    n_state = ST_PERM;
                end
            end
            ST_PERM: begin
                if (r_full != 38'd0) begin
                    l_go = 1'b1; l_a = 64'(r_rem); l_b = 64'd1000; l_n = 7'd10;
                    n_state = ST_PMUL;
                end else begin
                    n_permille = 10'd0;
                    n_state    = ST_RUN;
                end
            end
            ST_PMUL: begin
                if (!r_run) begin
                    l_go = 1'b1; l_op = OP_DIV; l_a = 64'(r_full); l_b = r_acc;
                    l_n = DIV_STEPS;
                    n_state = ST_PDIV;
                end
            end
            ST_PDIV: begin
                if (!r_run) begin
                    n_permille = r_mplier[9:0];
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                n_run_ok  = (r_cur >= {1'b0, r_run_min});
                n_low_run = 1'b0;
                if ((r_cur >= {1'b0, r_run_min}) && (r_cur != 16'd0)) begin
                    l_go = 1'b1; l_a = 64'd6000; l_b = 64'(r_cur); l_n = 7'd16;
                    n_state = ST_RMUL;
                end else begin
                    n_runtime = (r_cur >= {1'b0, r_run_min}) ? RUNTIME_MAX : 24'd0;
                    n_state   = ST_DONE;
                end
            end
            ST_RMUL: begin
                if (!r_run) begin
                    l_go = 1'b1; l_op = OP_DIV; l_a = r_acc; l_b = 64'(r_rem);
                    l_n = DIV_STEPS;
                    n_state = ST_RDIV;
                end
            end
            ST_RDIV: begin
                if (!r_run) begin
                    n_runtime = (r_mplier > 64'(RUNTIME_MAX)) ? RUNTIME_MAX : r_mplier[23:0];
                    l_go = 1'b1; l_a = 64'd600000; l_b = 64'(r_cur); l_n = 7'd16;
                    n_state = ST_LMUL;
                end
            end
            ST_LMUL: begin
                if (!r_run) begin
                    n_low_run = (64'(r_rem) <= r_acc);
                    n_state   = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_store = r_rem;
                    n_out.abs_current_ma          = r_cur;
                    n_out.consumed_charge         = r_used;
                    n_out.remaining_charge        = r_rem;
                    n_out.remaining_permille      = r_permille;
                    n_out.runtime_valid           = r_run_ok;
                    n_out.runtime_deci_min        = r_runtime;
                    n_out.voltage_estimate_valid  = r_vest;
                    n_out.voltage_charge_estimate = r_est;
                    n_out.warning_code            = w_warn;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Shared unit: shift-add multiply or restoring divide, one bit a cycle
        if (r_run) begin
            if (r_op == OP_DIV) begin
                if (w_rem_sh >= r_mcand) begin
                    n_acc    = w_rem_sh - r_mcand;
                    n_mplier = {r_mplier[62:0], 1'b1};
                end else begin
                    n_acc    = w_rem_sh;
                    n_mplier = {r_mplier[62:0], 1'b0};
                end
            end else begin
                if (r_mplier[0]) begin
                    n_acc = r_acc + r_mcand;
                end
                n_mcand  = {r_mcand[62:0], 1'b0};
                n_mplier = {1'b0, r_mplier[63:1]};
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_run = 1'b0;
            end
        end else if (l_go) begin
            n_op     = l_op;
            n_mcand  = l_a;
            n_mplier = l_b;
            n_cnt    = l_n;
            n_run    = 1'b1;
            if (!l_keep) begin
                n_acc = 64'd0;
            end
        end
    end

    // Checks
    a_idle_unit_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_run)
        else $error("arithmetic unit busy while idle");

    a_run_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> (r_cnt != 7'd0))
        else $error("arithmetic unit running with zero step count");

    a_init_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_init))
        else $error("charge initialization flag cleared");

    a_permille_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.remaining_permille <= 10'd1000))
        else $error("permille above 1000");

    a_runtime_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.runtime_valid) |-> (r_out.runtime_deci_min == 24'd0))
        else $error("runtime reported below minimum current");

endmodule
